/* sv/hbmt_pkg.sv */
// ----------------------------------------------------------------------------
// hbmt_pkg: shared definitions for the heartbeat membership table
// Table geometry, field widths, request and result codes, register
// indexes and the packed layouts of a table entry and an eviction record.
// ----------------------------------------------------------------------------
package hbmt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths.
   localparam int ID_W   = 32;
   localparam int PORT_W = 16;
   localparam int BEAT_W = 31;
   localparam int THR_W  = 16;
   localparam int KIND_W = 3;
   localparam int REQ_W  = 2;

   localparam logic [BEAT_W-1:0] BEAT_MAX = {BEAT_W{1'b1}};

   // Request codes carried in the low bits of the request tuser.
   localparam logic [REQ_W-1:0] REQ_INSERT    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_HEARTBEAT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK      = 2'd2;

   // Result codes carried in the response tuser.
   localparam logic [KIND_W-1:0] KIND_INSERTED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TABLE_FULL   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HB_APPLIED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN_ID   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EVICTED      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_TICK_DONE    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_TICK_IGNORED = 3'd6;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_INTRO     = 2'd1;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W = ((ID_W + PORT_W + BEAT_W + 7) / 8) * 8;
   localparam int REQ_USER_W = REQ_W + 1;
   localparam int RSP_DATA_W = ((ID_W + PORT_W + BEAT_W + CNT_W + 7) / 8) * 8;
   localparam int RSP_USER_W = KIND_W;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PORT_W-1:0] port;
      logic [BEAT_W-1:0] beat;
      logic [BEAT_W-1:0] ltime;
   } entry_type;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [ID_W-1:0]   id;
   } evict_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_WALK    = 5'b00010,
      ST_EMIT_RD = 5'b00100,
      ST_EMIT_WR = 5'b01000,
      ST_FINAL   = 5'b10000
   } state_type;

endpackage

/* sv/hbmt_ram.sv */
// ----------------------------------------------------------------------------
// hbmt_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read that holds its
// value while no read is requested.
// ----------------------------------------------------------------------------
module hbmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/heartbeat_membership_table_unit.sv */
// ----------------------------------------------------------------------------
// heartbeat_membership_table_unit: membership table of a heartbeat detector
// Ordered member table with insert, heartbeat report and tick with
// threshold eviction and in-order compaction.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ stream; tuser holds the request type and the
// join-reply flag, tdata holds member id, port and heartbeat. Each request
// produces one or more transactions on the rsp_ stream; tlast marks the final
// transaction of a request and tuser holds the result kind. An unused request
// type is consumed and produces no transaction.
// The block takes one request at a time: req_tready is high only while the
// sequencer is idle. One table entry is read per cycle from the table RAM
// through a single compare and update unit, and evicted members are buffered
// in a second RAM and replayed one at a time, each read back from the buffer
// before it is handed to the output register.
// The response is held in an output register, so a stalled receiver only
// delays the sequencer when it must hand over the next transaction.
// Reset empties the table, clears the own heartbeat, loads the default
// threshold of 5 and leaves the node not joined. The RAM contents are not
// cleared; only entries below the member count are ever read.
// Configuration writes are taken at any time on the csr_ port and must only
// be issued while no request is in progress.
// ----------------------------------------------------------------------------
module heartbeat_membership_table_unit (
   input  logic                            clock,
   input  logic                            reset,
   // Request stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata from bit 0: member_id[31:0], member_port[15:0],
   // heartbeat_value[30:0], zero pad.
   input  logic [hbmt_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser from bit 0: req_type[1:0], from_join_reply.
   input  logic [hbmt_pkg::REQ_USER_W-1:0] req_tuser,
   // Response stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata from bit 0: out_member_id[31:0], out_member_port[15:0],
   // own_heartbeat[30:0], member_count, zero pad.
   output logic [hbmt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser from bit 0: result_kind[2:0].
   output logic [hbmt_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast,
   // Configuration write port.
   input  logic                            csr_wr_en,
   input  logic [hbmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hbmt_pkg::THR_W-1:0]      csr_wr_data
);

   import hbmt_pkg::*;

   // Sequencer and architectural state.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BEAT_W-1:0] own_beat_ff, own_beat_in;
   logic              joined_ff, joined_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic              intro_ff, intro_in;

   // Per-request working registers.
   logic [ID_W-1:0]   id_ff, id_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic              op_tick_ff, op_tick_in;
   logic              found_ff, found_in;
   logic [PORT_W-1:0] first_port_ff, first_port_in;
   logic [CNT_W-1:0]  walk_idx_ff, walk_idx_in;
   logic [IDX_W-1:0]  proc_idx_ff, proc_idx_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  keep_ff, keep_in;
   logic [CNT_W-1:0]  ev_n_ff, ev_n_in;
   logic [CNT_W-1:0]  emit_idx_ff, emit_idx_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [PORT_W-1:0] rsp_port_ff, rsp_port_in;
   logic [BEAT_W-1:0] rsp_beat_ff, rsp_beat_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   // Request fields.
   logic [REQ_W-1:0]  req_type;
   logic [ID_W-1:0]   req_id;
   logic [PORT_W-1:0] req_port;
   logic [BEAT_W-1:0] req_beat;
   logic              req_join;
   logic              req_accept;

   // RAM ports.
   logic             tbl_we, tbl_re;
   logic [IDX_W-1:0] tbl_waddr;
   entry_type        tbl_wdata, tbl_rdata;
   logic             ev_we, ev_re;
   evict_type        ev_wdata, ev_rdata;

   // Compare and update unit.
   logic [BEAT_W:0]   diff;
   logic              evict;
   logic              id_match;
   logic [BEAT_W-1:0] time_inc;
   logic              issue;
   logic              out_free;
   logic              push;
   logic [KIND_W-1:0] push_kind;
   logic [ID_W-1:0]   push_id;
   logic [PORT_W-1:0] push_port;
   logic              push_last;

   assign req_type = req_tuser[REQ_W-1:0];
   assign req_join = req_tuser[REQ_W];
   assign req_id   = req_tdata[ID_W-1:0];
   assign req_port = req_tdata[ID_W +: PORT_W];
   assign req_beat = req_tdata[ID_W + PORT_W +: BEAT_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Walk the table while entries remain; the RAM read is registered.
   assign issue = (walk_idx_ff < count_ff);

   // An entry is evicted when its time is not behind its heartbeat and the
   // gap reaches the threshold.
   assign diff     = {1'b0, tbl_rdata.ltime} - {1'b0, tbl_rdata.beat};
   assign evict    = !diff[BEAT_W] && (diff[BEAT_W-1:0] >= BEAT_W'(thr_ff));
   assign id_match = (tbl_rdata.id == id_ff);
   assign time_inc = (tbl_rdata.ltime == BEAT_MAX) ? tbl_rdata.ltime
                                                   : tbl_rdata.ltime + 1'b1;

   assign tbl_re = (state_ff == ST_WALK) && issue;
   assign ev_re  = (state_ff == ST_EMIT_RD);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      own_beat_in   = own_beat_ff;
      joined_in     = joined_ff;
      thr_in        = thr_ff;
      intro_in      = intro_ff;
      id_in         = id_ff;
      port_in       = port_ff;
      beat_in       = beat_ff;
      kind_in       = kind_ff;
      op_tick_in    = op_tick_ff;
      found_in      = found_ff;
      first_port_in = first_port_ff;
      walk_idx_in   = walk_idx_ff;
      proc_idx_in   = proc_idx_ff;
      pend_in       = pend_ff;
      keep_in       = keep_ff;
      ev_n_in       = ev_n_ff;
      emit_idx_in   = emit_idx_ff;
      tbl_we        = 1'b0;
      tbl_waddr     = proc_idx_ff;
      tbl_wdata     = tbl_rdata;
      ev_we         = 1'b0;
      ev_wdata      = '{port: tbl_rdata.port, id: tbl_rdata.id};
      push          = 1'b0;
      push_kind     = kind_ff;
      push_id       = id_ff;
      push_port     = port_ff;
      push_last     = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               id_in   = req_id;
               port_in = req_port;
               beat_in = req_beat;
               case (req_type)
                  REQ_INSERT: begin
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = count_ff[IDX_W-1:0];
                        tbl_wdata = '{id: req_id, port: req_port, beat: req_beat,
                                      ltime: req_join ? '0 : req_beat};
                        count_in  = count_ff + 1'b1;
                        kind_in   = KIND_INSERTED;
                     end else begin
                        kind_in   = KIND_TABLE_FULL;
                     end
                     if (req_join) begin
                        joined_in = 1'b1;
                     end
                     state_in = ST_FINAL;
                  end
                  REQ_HEARTBEAT: begin
                     op_tick_in    = 1'b0;
                     found_in      = 1'b0;
                     first_port_in = '0;
                     walk_idx_in   = '0;
                     pend_in       = 1'b0;
                     state_in      = ST_WALK;
                  end
                  REQ_TICK: begin
                     if (!joined_ff) begin
                        kind_in  = KIND_TICK_IGNORED;
                        id_in    = '0;
                        port_in  = '0;
                        state_in = ST_FINAL;
                     end else begin
                        if (own_beat_ff != BEAT_MAX) begin
                           own_beat_in = own_beat_ff + 1'b1;
                        end
                        op_tick_in  = 1'b1;
                        walk_idx_in = '0;
                        pend_in     = 1'b0;
                        keep_in     = '0;
                        ev_n_in     = '0;
                        state_in    = ST_WALK;
                     end
                  end
                  default: begin
                     // Unused request code: consumed without a response.
                  end
               endcase
            end
         end

         ST_WALK: begin
            pend_in = issue;
            if (issue) begin
               walk_idx_in = walk_idx_ff + 1'b1;
               proc_idx_in = walk_idx_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               if (op_tick_ff) begin
                  if (evict) begin
                     ev_we   = 1'b1;
                     ev_n_in = ev_n_ff + 1'b1;
                  end else begin
                     // Survivors move down to the compacted position.
                     tbl_we          = 1'b1;
                     tbl_waddr       = keep_ff[IDX_W-1:0];
                     tbl_wdata.ltime = time_inc;
                     keep_in         = keep_ff + 1'b1;
                  end
               end else if (id_match) begin
                  tbl_we         = 1'b1;
                  tbl_wdata.beat = beat_ff;
                  if (!found_ff) begin
                     first_port_in = tbl_rdata.port;
                  end
                  found_in = 1'b1;
               end
            end
            if (!issue && !pend_ff) begin
               if (op_tick_ff) begin
                  count_in    = keep_ff;
                  kind_in     = KIND_TICK_DONE;
                  id_in       = '0;
                  port_in     = '0;
                  emit_idx_in = '0;
                  state_in    = (ev_n_ff != '0) ? ST_EMIT_RD : ST_FINAL;
               end else begin
                  kind_in  = found_ff ? KIND_HB_APPLIED : KIND_UNKNOWN_ID;
                  port_in  = found_ff ? first_port_ff : '0;
                  state_in = ST_FINAL;
               end
            end
         end

         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end

         ST_EMIT_WR: begin
            if (out_free) begin
               push        = 1'b1;
               push_kind   = KIND_EVICTED;
               push_id     = ev_rdata.id;
               push_port   = ev_rdata.port;
               push_last   = 1'b0;
               emit_idx_in = emit_idx_ff + 1'b1;
               state_in    = (emit_idx_ff + 1'b1 == ev_n_ff) ? ST_FINAL : ST_EMIT_RD;
            end
         end

         ST_FINAL: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes; a set introducer flag also joins the group.
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FAIL_THRESHOLD: thr_in = csr_wr_data;
            CSR_SELF_INTRO: begin
               intro_in = csr_wr_data[0];
               if (csr_wr_data[0]) begin
                  joined_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Output register load; counts and heartbeat are already final here.
   always_comb begin
      rsp_valid_in = push || (rsp_valid_ff && !rsp_tready);
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_port_in  = rsp_port_ff;
      rsp_beat_in  = rsp_beat_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_kind_in  = push_kind;
         rsp_id_in    = push_id;
         rsp_port_in  = push_port;
         rsp_beat_in  = own_beat_ff;
         rsp_count_in = count_ff;
         rsp_last_in  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         own_beat_ff  <= '0;
         joined_ff    <= 1'b0;
         thr_ff       <= THR_W'(5);
         intro_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         own_beat_ff  <= own_beat_in;
         joined_ff    <= joined_in;
         thr_ff       <= thr_in;
         intro_ff     <= intro_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      port_ff       <= port_in;
      beat_ff       <= beat_in;
      kind_ff       <= kind_in;
      op_tick_ff    <= op_tick_in;
      found_ff      <= found_in;
      first_port_ff <= first_port_in;
      walk_idx_ff   <= walk_idx_in;
      proc_idx_ff   <= proc_idx_in;
      pend_ff       <= pend_in;
      keep_ff       <= keep_in;
      ev_n_ff       <= ev_n_in;
      emit_idx_ff   <= emit_idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_beat_ff   <= rsp_beat_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Member table: one entry per member in table order.
   hbmt_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(TABLE_DEPTH)
   ) u_table_ram (
      .clock  (clock),
      .wr_en  (tbl_we),
      .wr_addr(tbl_waddr),
      .wr_data(tbl_wdata),
      .rd_en  (tbl_re),
      .rd_addr(walk_idx_ff[IDX_W-1:0]),
      .rd_data(tbl_rdata)
   );

   // Eviction buffer: members removed by the current tick, in table order.
   hbmt_ram #(
      .WIDTH($bits(evict_type)),
      .DEPTH(TABLE_DEPTH)
   ) u_evict_ram (
      .clock  (clock),
      .wr_en  (ev_we),
      .wr_addr(ev_n_ff[IDX_W-1:0]),
      .wr_data(ev_wdata),
      .rd_en  (ev_re),
      .rd_addr(emit_idx_ff[IDX_W-1:0]),
      .rd_data(ev_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_beat_ff, rsp_port_ff, rsp_id_ff});

   // The member count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("member count exceeds table depth");

   // During a tick walk, survivors plus evictions never exceed the members.
   a_walk_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && op_tick_ff) |->
         (CNT_W'(keep_ff + ev_n_ff) <= count_ff))
      else $error("tick walk accounted for more entries than present");

   // Replay of evictions only runs while buffered evictions remain.
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_WR) |-> (emit_idx_ff < ev_n_ff))
      else $error("eviction replay index out of range");

   // A tick before joining goes straight to a single ignored response.
   a_tick_ignored: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_type == REQ_TICK && !joined_ff) |=>
         (state_ff == ST_FINAL && kind_ff == KIND_TICK_IGNORED))
      else $error("tick before join was not ignored");

   // An eviction transaction is never the last one of its request.
   a_evict_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_EVICTED) |-> !rsp_tlast)
      else $error("eviction marked as last transaction");

endmodule

/* verif/tb_heartbeat_membership_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heartbeat_membership_table_unit: self-checking bench for the member table
// Drives inserts, heartbeat reports and ticks with random gaps and stalls.
// A scoreboard keeps its own copy of the table and predicts every result
// transaction; each one returned by the unit is compared field by field.
// ----------------------------------------------------------------------------
module tb_heartbeat_membership_table_unit;
   import hbmt_pkg::*;

   // Request type that the unit consumes without any response.
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   // Bit offsets inside the request and response tdata words.
   localparam int ID_LO   = 0;
   localparam int PORT_LO = ID_LO + ID_W;
   localparam int BEAT_LO = PORT_LO + PORT_W;
   localparam int CNT_LO  = BEAT_LO + BEAT_W;

   // Cycles to let pass after the last result before a register write, so a
   // request that produced no transaction has surely left the sequencer.
   localparam int SETTLE_CYCLES = 80;
   // Cycles without any accepted transaction before the run is abandoned.
   // The slowest legal gap is a full-table tick plus a receiver stall, or a settle pause.
   localparam int STALL_LIMIT = 3000;

   // One result transaction as seen on the response stream.
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic [PORT_W-1:0] port;
      logic [BEAT_W-1:0] own_beat;
      logic [CNT_W-1:0]  count;
      logic              last;
   } member_result_type;

   // The scoreboard holds a private copy of the membership table and the
   // registers. Every accepted request updates that copy and queues the
   // transactions the unit must return for it.
   class membership_scoreboard;
      logic [THR_W-1:0]  threshold;
      bit                introducer;
      bit                joined;
      logic [ID_W-1:0]   ids[TABLE_DEPTH];
      logic [PORT_W-1:0] ports[TABLE_DEPTH];
      logic [BEAT_W-1:0] beats[TABLE_DEPTH];
      logic [BEAT_W-1:0] ltimes[TABLE_DEPTH];
      int                count;
      logic [BEAT_W-1:0] own_beat;
      member_result_type expected[$];
      int                errors;

      function new();
         threshold  = 16'd5;
         introducer = 1'b0;
         joined     = 1'b0;
         count      = 0;
         own_beat   = '0;
         errors     = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [THR_W-1:0] val);
         if (idx == CSR_FAIL_THRESHOLD) begin
            threshold = val;
         end else if (idx == CSR_SELF_INTRO) begin
            introducer = val[0];
            if (val[0]) begin
               joined = 1'b1;
            end
         end
      endfunction

      function void queue_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                 logic [PORT_W-1:0] port, logic last);
         member_result_type r;
         r.kind     = kind;
         r.id       = id;
         r.port     = port;
         r.own_beat = own_beat;
         r.count    = CNT_W'(count);
         r.last     = last;
         expected.insert(expected.size(), r);
      endfunction

      function void note_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                 logic [PORT_W-1:0] port, logic [BEAT_W-1:0] beat,
                                 bit join_reply);
         logic [ID_W-1:0]   gone_ids[TABLE_DEPTH];
         logic [PORT_W-1:0] gone_ports[TABLE_DEPTH];
         int                ngone;
         int                keep;
         bit                found;
         logic [PORT_W-1:0] first_port;
         ngone      = 0;
         keep       = 0;
         found      = 1'b0;
         first_port = '0;
         case (req)
            REQ_INSERT: begin
               if (count < TABLE_DEPTH) begin
                  ids[count]    = id;
                  ports[count]  = port;
                  beats[count]  = beat;
                  ltimes[count] = join_reply ? '0 : beat;
                  count++;
                  if (join_reply) joined = 1'b1;
                  queue_result(KIND_INSERTED, id, port, 1'b1);
               end else begin
                  if (join_reply) joined = 1'b1;
                  queue_result(KIND_TABLE_FULL, id, port, 1'b1);
               end
            end
            REQ_HEARTBEAT: begin
               for (int i = 0; i < count; i++) begin
                  if (ids[i] == id) begin
                     if (!found) first_port = ports[i];
                     found    = 1'b1;
                     beats[i] = beat;
                  end
               end
               if (found) queue_result(KIND_HB_APPLIED, id, first_port, 1'b1);
               else queue_result(KIND_UNKNOWN_ID, id, '0, 1'b1);
            end
            REQ_TICK: begin
               if (!joined) begin
                  queue_result(KIND_TICK_IGNORED, '0, '0, 1'b1);
               end else begin
                  if (own_beat != BEAT_MAX) own_beat++;
                  for (int i = 0; i < count; i++) begin
                     if (longint'(ltimes[i]) - longint'(beats[i]) >= longint'(threshold)) begin
                        gone_ids[ngone]   = ids[i];
                        gone_ports[ngone] = ports[i];
                        ngone++;
                     end else begin
                        ids[keep]    = ids[i];
                        ports[keep]  = ports[i];
                        beats[keep]  = beats[i];
                        ltimes[keep] = (ltimes[i] != BEAT_MAX) ? ltimes[i] + 1'b1 : ltimes[i];
                        keep++;
                     end
                  end
                  count = keep;
                  for (int k = 0; k < ngone; k++) begin
                     queue_result(KIND_EVICTED, gone_ids[k], gone_ports[k], 1'b0);
                  end
                  queue_result(KIND_TICK_DONE, '0, '0, 1'b1);
               end
            end
            default: begin
            end
         endcase
      endfunction

      task report(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_field(string name, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
         if (got !== want) begin
            report($sformatf("%s is %0h, expected %0h", name, got, want));
         end
      endtask

      task check_result(member_result_type got);
         member_result_type want;
         if (expected.size() == 0) begin
            report($sformatf("unexpected transaction kind %0d id %0h", got.kind, got.id));
            return;
         end
         want = expected.pop_front();
         check_field("result_kind", got.kind, want.kind);
         check_field("out_member_id", got.id, want.id);
         check_field("out_member_port", got.port, want.port);
         check_field("own_heartbeat", got.own_beat, want.own_beat);
         check_field("member_count", got.count, want.count);
         check_field("last", got.last, want.last);
      endtask
   endclass

   // Clock, reset and the signals of the unit.
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [THR_W-1:0]      csr_wr_data;

   membership_scoreboard sb;
   member_result_type    rsp_seen;
   bit                   idling_on = 1'b1;
   int                   quiet_cycles = 0;

   always #5 clock = ~clock;

   heartbeat_membership_table_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Gap lengths: mostly none or short, now and then a long one. With idling
   // switched off both sides run back to back.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idling_on) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Heartbeat values: mostly small so that ticks can catch up with them,
   // sometimes any 31-bit value, sometimes right at the top of the range.
   function automatic logic [BEAT_W-1:0] pick_beat();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return BEAT_W'($urandom_range(0, 40));
      if (r < 85) return BEAT_W'($urandom);
      return BEAT_MAX - BEAT_W'($urandom_range(0, 3));
   endfunction

   // Member ids come from a small pool half of the time, so duplicates
   // appear in the table and a report can hit several entries.
   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 1) == 0) return ID_W'($urandom_range(1, 8));
      return $urandom;
   endfunction

   // The receiver: ready changes only at the falling edge, and a stall is
   // started now and then with a length drawn from pick_gap.
   initial begin
      int hold;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) hold = pick_gap();
         end
      end
   end

   // Every response transaction is checked at the rising edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen.kind     = rsp_tuser[KIND_W-1:0];
         rsp_seen.id       = rsp_tdata[ID_LO +: ID_W];
         rsp_seen.port     = rsp_tdata[PORT_LO +: PORT_W];
         rsp_seen.own_beat = rsp_tdata[BEAT_LO +: BEAT_W];
         rsp_seen.count    = rsp_tdata[CNT_LO +: CNT_W];
         rsp_seen.last     = rsp_tlast;
         sb.check_result(rsp_seen);
      end
   end

   // Watchdog: any accepted transaction on either stream restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Presents one request at the falling edge and holds it until the unit
   // takes it. Valid is left high so that a following request with no gap
   // simply replaces the payload at the next falling edge.
   task automatic send_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                               logic [PORT_W-1:0] port, logic [BEAT_W-1:0] beat,
                               bit join_reply);
      logic [REQ_DATA_W-1:0] data;
      data                     = '0;
      data[ID_LO +: ID_W]      = id;
      data[PORT_LO +: PORT_W]  = port;
      data[BEAT_LO +: BEAT_W]  = beat;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= {join_reply, req};
      do @(posedge clock); while (!req_tready);
      sb.note_request(req, id, port, beat, join_reply);
   endtask

   // Drops valid for a number of cycles between requests.
   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Holds off the sender until every predicted transaction has come back,
   // and optionally waits out a request that produced no response at all.
   task automatic wait_for_results(bit settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [THR_W-1:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_register(idx, val);
   endtask

   // Random traffic. Heartbeat reports mostly name a member that is in the
   // table, with a value near its local time, so ticks keep evicting some
   // members and sparing others. A few requests carry the unused type.
   task automatic run_traffic(int items, int insert_pct);
      int                r;
      int                k;
      int                delta;
      logic [BEAT_W-1:0] base;
      logic [BEAT_W-1:0] beat;
      logic [ID_W-1:0]   id;
      for (int n = 0; n < items; n++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 4) wait_for_results(1'b0);
         if (r < insert_pct) begin
            send_request(REQ_INSERT, pick_id(), PORT_W'($urandom_range(0, 65535)),
                         pick_beat(), $urandom_range(0, 4) == 0);
         end else if (r >= 97) begin
            send_request(REQ_UNUSED, $urandom, PORT_W'($urandom_range(0, 65535)),
                         BEAT_W'($urandom), $urandom_range(0, 1));
         end else if ($urandom_range(0, 1) == 0) begin
            if (sb.count > 0 && $urandom_range(0, 3) != 0) begin
               k     = $urandom_range(0, sb.count - 1);
               id    = sb.ids[k];
               base  = sb.ltimes[k];
               delta = $urandom_range(0, 8);
               if ($urandom_range(0, 4) == 0) begin
                  beat = (base > BEAT_MAX - BEAT_W'(delta)) ? BEAT_MAX : base + BEAT_W'(delta);
               end else begin
                  beat = (base >= BEAT_W'(delta)) ? base - BEAT_W'(delta) : '0;
               end
            end else begin
               id   = pick_id();
               beat = pick_beat();
            end
            send_request(REQ_HEARTBEAT, id, PORT_W'($urandom_range(0, 65535)), beat,
                         $urandom_range(0, 1));
         end else begin
            send_request(REQ_TICK, $urandom, PORT_W'($urandom_range(0, 65535)),
                         BEAT_W'($urandom), $urandom_range(0, 1));
         end
         pause_sender(pick_gap());
      end
   endtask

   // One phase: quiesce, load the registers, then random traffic.
   // A negative introducer value leaves that register alone.
   task automatic run_phase(logic [THR_W-1:0] threshold, int introducer, bit idle,
                            int items, int insert_pct);
      wait_for_results(1'b1);
      write_register(CSR_FAIL_THRESHOLD, threshold);
      if (introducer >= 0) write_register(CSR_SELF_INTRO, THR_W'(introducer));
      idling_on = idle;
      run_traffic(items, insert_pct);
   endtask

   initial begin
      sb          = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wr_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings (threshold 5, not joined).
      // Before joining, ticks are ignored; an empty table knows no id; the
      // unused type is swallowed without a response.
      send_request(REQ_TICK, '0, '0, '0, 1'b0);
      send_request(REQ_HEARTBEAT, 32'h1234_5678, 16'h00ff, 31'd7, 1'b0);
      send_request(REQ_UNUSED, '1, '1, BEAT_MAX, 1'b1);
      send_request(REQ_INSERT, '0, '0, '0, 1'b0);
      send_request(REQ_TICK, '1, '1, BEAT_MAX, 1'b1);
      // Clearing the introducer bit must not make the node join.
      wait_for_results(1'b1);
      write_register(CSR_SELF_INTRO, '0);
      send_request(REQ_TICK, '0, '0, '0, 1'b0);
      // A join reply joins the node and starts the member's time at zero,
      // so its large heartbeat makes the difference negative.
      send_request(REQ_INSERT, '1, '1, BEAT_MAX, 1'b1);
      send_request(REQ_INSERT, 32'd5, 16'h1234, 31'd100, 1'b0);
      pause_sender(pick_gap());
      send_request(REQ_INSERT, 32'd5, 16'h5678, 31'd200, 1'b0);
      // A member whose time starts at the top saturates on every tick.
      send_request(REQ_INSERT, 32'd9, 16'h0007, BEAT_MAX, 1'b0);
      // Both entries with id 5 take the report; the first port is returned.
      send_request(REQ_HEARTBEAT, 32'd5, '0, 31'd90, 1'b0);
      send_request(REQ_HEARTBEAT, '0, '1, 31'd3, 1'b1);
      send_request(REQ_TICK, '0, '0, '0, 1'b0);
      pause_sender(pick_gap());
      send_request(REQ_HEARTBEAT, 32'hdead_beef, 16'h8001, 31'h4000_0001, 1'b0);
      send_request(REQ_TICK, '0, '0, '0, 1'b0);
      send_request(REQ_TICK, '0, '0, '0, 1'b0);
      send_request(REQ_INSERT, 32'h8000_0000, 16'h8000, 31'h4000_0000, 1'b1);
      send_request(REQ_INSERT, 32'h0000_0001, 16'h0001, 31'd0, 1'b1);
      send_request(REQ_TICK, '0, '0, '0, 1'b0);
      send_request(REQ_TICK, '0, '0, '0, 1'b0);
      send_request(REQ_UNUSED, '0, '0, '0, 1'b0);

      // Largest threshold with mostly inserts: the table fills up and
      // further inserts, join replies among them, are dropped.
      run_phase(16'hffff, 1, 1'b1, 90, 80);
      // Threshold of one: most members go on the next tick, so
      // ticks return long runs of evictions.
      run_phase(16'd1, -1, 1'b1, 80, 40);
      // Zero threshold, no idling on either side.
      run_phase(16'd0, 0, 1'b0, 60, 40);
      run_phase(THR_W'($urandom_range(2, 12)), -1, 1'b1, 80, 45);
      run_phase(16'd3, -1, 1'b1, 80, 35);

      wait_for_results(1'b1);
      if (sb.expected.size() != 0) sb.report("transactions still missing at the end");
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
sv/hbmt_pkg.sv
sv/hbmt_ram.sv
sv/heartbeat_membership_table_unit.sv
verif/tb_heartbeat_membership_table_unit.sv
